### rtl/pli_pkg.sv
// Shared types and constants for the positional list block.
package pli_pkg;

  localparam int DEPTH = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W = 7;
  localparam int POS_W = 7;
  localparam int DATA_W = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] removed_value;
    logic [CNT_W-1:0]         new_length;
  } result_t;

  typedef struct packed {
    logic load;
    logic check;
    logic rd_first;
    logic rd;
    logic capture;
    logic wr_shift;
    logic wr_value;
    logic dec_count;
  } dp_cmd_t;

  typedef struct packed {
    logic opcode;
    logic legal;
    logic more;
  } dp_status_t;

endpackage

### rtl/pli_dp.sv
// Datapath: element memory, length, sweep index and result registers.
module pli_dp (
  input  logic               clk,
  input  logic               rst,
  input  pli_pkg::request_t  request,
  input  pli_pkg::dp_cmd_t   cmd,
  output pli_pkg::dp_status_t status,
  output pli_pkg::result_t   result
);

  logic signed [pli_pkg::DATA_W-1:0] mem [pli_pkg::DEPTH];
  logic signed [pli_pkg::DATA_W-1:0] rdata;
  logic signed [pli_pkg::DATA_W-1:0] val;
  logic signed [pli_pkg::DATA_W-1:0] removed;
  logic                              op;
  logic [pli_pkg::POS_W-1:0]         pos;
  logic [pli_pkg::CNT_W-1:0]         count;
  logic [pli_pkg::CNT_W-1:0]         idx;
  logic                              ok;
  logic [pli_pkg::CNT_W-1:0]         pos_m1;
  logic [pli_pkg::CNT_W-1:0]         rd_ptr;
  logic [pli_pkg::CNT_W-1:0]         wr_ptr;
  logic                              legal;
  logic                              wr_en;

  assign pos_m1 = pos - pli_pkg::CNT_W'(1);

  always_comb begin
    if (op == pli_pkg::OP_INSERT) begin
      legal = (pos != '0) &&
              ({1'b0, pos} <= ({1'b0, count} + (pli_pkg::CNT_W + 1)'(1))) &&
              (count < pli_pkg::CNT_W'(pli_pkg::DEPTH));
    end else begin
      legal = (pos != '0) && (pos <= count);
    end
  end

  assign status.opcode = op;
  assign status.legal  = legal;
  assign status.more   = (op == pli_pkg::OP_INSERT) ? (idx >= pos) : (idx < count);

  always_comb begin
    if (cmd.rd_first) begin
      rd_ptr = pos_m1;
    end else if (op == pli_pkg::OP_INSERT) begin
      rd_ptr = idx - pli_pkg::CNT_W'(1);
    end else begin
      rd_ptr = idx;
    end
    if (cmd.wr_value) begin
      wr_ptr = pos_m1;
    end else if (op == pli_pkg::OP_INSERT) begin
      wr_ptr = idx;
    end else begin
      wr_ptr = idx - pli_pkg::CNT_W'(1);
    end
  end

  assign wr_en = cmd.wr_shift | cmd.wr_value;

  always_ff @(posedge clk) begin
    if (cmd.rd | cmd.rd_first) begin
      rdata <= mem[rd_ptr[pli_pkg::ADDR_W-1:0]];
    end
    if (wr_en) begin
      mem[wr_ptr[pli_pkg::ADDR_W-1:0]] <= cmd.wr_value ? val : rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= request.opcode;
      pos <= request.position;
      val <= request.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      idx     <= '0;
      ok      <= 1'b0;
      removed <= '0;
    end else begin
      if (cmd.load) begin
        idx     <= (request.opcode == pli_pkg::OP_INSERT) ? count : request.position;
        removed <= '0;
      end else if (cmd.wr_shift) begin
        idx <= (op == pli_pkg::OP_INSERT) ? idx - pli_pkg::CNT_W'(1)
                                          : idx + pli_pkg::CNT_W'(1);
      end
      if (cmd.check) begin
        ok <= legal;
      end
      if (cmd.capture) begin
        removed <= rdata;
      end
      if (cmd.wr_value) begin
        count <= count + pli_pkg::CNT_W'(1);
      end else if (cmd.dec_count) begin
        count <= count - pli_pkg::CNT_W'(1);
      end
    end
  end

  assign result.ok            = ok;
  assign result.removed_value = removed;
  assign result.new_length    = count;

endmodule

### rtl/pli_ctrl.sv
// Controller state machine that sequences the element shift sweep.
module pli_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  pli_pkg::dp_status_t  status,
  output pli_pkg::dp_cmd_t     cmd,
  output logic                 busy,
  output logic                 done
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CHECK   = 9'b000000010,
    S_INS_RD  = 9'b000000100,
    S_INS_WR  = 9'b000001000,
    S_DEL_RD0 = 9'b000010000,
    S_DEL_CAP = 9'b000100000,
    S_DEL_RD  = 9'b001000000,
    S_DEL_WR  = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (!status.legal) begin
          state_next = S_DONE;
        end else if (status.opcode == pli_pkg::OP_INSERT) begin
          state_next = S_INS_RD;
        end else begin
          state_next = S_DEL_RD0;
        end
      end
      S_INS_RD: begin
        if (status.more) begin
          cmd.rd     = 1'b1;
          state_next = S_INS_WR;
        end else begin
          cmd.wr_value = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_INS_WR: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_INS_RD;
      end
      S_DEL_RD0: begin
        cmd.rd_first = 1'b1;
        state_next   = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        cmd.capture = 1'b1;
        state_next  = S_DEL_RD;
      end
      S_DEL_RD: begin
        if (status.more) begin
          cmd.rd     = 1'b1;
          state_next = S_DEL_WR;
        end else begin
          cmd.dec_count = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_DEL_WR: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_DEL_RD;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

### rtl/positional_list_insert_delete.sv
// Top level of the positional list insert and delete block.
// A request is taken when start is high and busy is low; busy then stays high until the
// single result has been shown with done for one cycle, and the receiver cannot stall it.
// The elements live in a 64-entry memory with one read and one write port, so a request
// moves the elements one at a time, each read in a read state and then written back in a
// write state; a rejected request goes from the legality check straight to done.
module positional_list_insert_delete (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pli_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output pli_pkg::result_t  result
);

  pli_pkg::dp_cmd_t    cmd;
  pli_pkg::dp_status_t status;

  pli_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  pli_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .result  (result)
  );

  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block stayed busy after a result");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not start work");

  a_reject_no_value: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |-> (result.removed_value == '0))
    else $error("rejected request returned a removed value");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.new_length <= pli_pkg::CNT_W'(pli_pkg::DEPTH)))
    else $error("list length exceeds depth");

endmodule

### test/pli_list_checker.sv
// Checker that predicts and compares every result of the positional list block.
module pli_list_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  pli_pkg::request_t request,
  input  logic              done,
  input  pli_pkg::result_t  result,
  output int                failures,
  output int                pending,
  output int                length
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [pli_pkg::DATA_W-1:0] shadow_list[$];
  pli_pkg::result_t                  expected_results[$];
  pli_pkg::result_t                  oldest;

  function automatic pli_pkg::result_t apply_list_op(pli_pkg::request_t req);
    pli_pkg::result_t res;
    int               pos;
    int               held;
    res  = '0;
    pos  = int'(req.position);
    held = shadow_list.size();
    if (req.opcode == pli_pkg::OP_INSERT) begin
      if (pos >= 1 && pos <= held + 1 && held < pli_pkg::DEPTH) begin
        shadow_list.insert(pos - 1, req.value);
        res.ok = 1'b1;
      end
    end else if (pos >= 1 && pos <= held) begin
      res.removed_value = shadow_list[pos - 1];
      shadow_list.delete(pos - 1);
      res.ok = 1'b1;
    end
    res.new_length = pli_pkg::CNT_W'(shadow_list.size());
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [pli_pkg::DATA_W-1:0] got,
                               logic [pli_pkg::DATA_W-1:0] want);
    $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result arrived with no request waiting", $time);
          failures++;
        end else begin
          oldest = expected_results.pop_front();
          if (result.ok !== oldest.ok) begin
            flag_mismatch("ok", pli_pkg::DATA_W'(result.ok), pli_pkg::DATA_W'(oldest.ok));
          end
          if (result.removed_value !== oldest.removed_value) begin
            flag_mismatch("removed_value", result.removed_value, oldest.removed_value);
          end
          if (result.new_length !== oldest.new_length) begin
            flag_mismatch("new_length", pli_pkg::DATA_W'(result.new_length),
                          pli_pkg::DATA_W'(oldest.new_length));
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_list_op(request));
      end
    end
    pending = expected_results.size();
    length  = shadow_list.size();
  end

endmodule

### test/testbench.sv
// Top of the positional list testbench: stimulus, checker instance and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  pli_pkg::request_t request = '0;
  logic              busy;
  logic              done;
  pli_pkg::result_t  result;
  int                failures;
  int                pending;
  int                length;
  bit                growing = 1'b1;
  int                sent;
  int                burst;

  always #5 clk = ~clk;

  positional_list_insert_delete u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  pli_list_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .failures(failures),
    .pending (pending),
    .length  (length)
  );

  task automatic present(logic op, int pos, logic [pli_pkg::DATA_W-1:0] val);
    start   <= 1'b1;
    request <= '{opcode: op, position: pli_pkg::POS_W'(pos), value: val};
    do @(posedge clk); while (busy);
  endtask

  task automatic issue(logic op, int pos, logic [pli_pkg::DATA_W-1:0] val);
    @(negedge clk);
    present(op, pos, val);
  endtask

  // Grows the list toward full, then shrinks it toward empty, with some malformed requests.
  task automatic issue_random();
    logic op;
    int   pos;
    @(negedge clk);
    if (length >= pli_pkg::DEPTH && $urandom_range(0, 3) == 0) begin
      growing = 1'b0;
    end else if (length == 0 && $urandom_range(0, 2) == 0) begin
      growing = 1'b1;
    end
    op = ($urandom_range(0, 9) < 8)
           ? (growing ? pli_pkg::OP_INSERT : pli_pkg::OP_DELETE)
           : (growing ? pli_pkg::OP_DELETE : pli_pkg::OP_INSERT);
    if ($urandom_range(0, 6) == 0) begin
      pos = $urandom_range(0, 127);
    end else if (op == pli_pkg::OP_INSERT) begin
      pos = $urandom_range(1, length + 1);
    end else begin
      pos = (length == 0) ? 1 : $urandom_range(1, length);
    end
    present(op, pos, $urandom());
  endtask

  task automatic idle(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain();
    idle(1);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue(pli_pkg::OP_DELETE, 1, 32'h0000_0001);
    issue(pli_pkg::OP_DELETE, 0, 32'h0000_0000);
    issue(pli_pkg::OP_DELETE, 127, 32'hFFFF_FFFF);
    issue(pli_pkg::OP_INSERT, 0, 32'h0000_1234);
    issue(pli_pkg::OP_INSERT, 2, 32'h0000_5678);
    issue(pli_pkg::OP_INSERT, 127, 32'hFFFF_FFFF);
    issue(pli_pkg::OP_INSERT, 1, 32'h8000_0000);
    issue(pli_pkg::OP_INSERT, 2, 32'h7FFF_FFFF);
    issue(pli_pkg::OP_INSERT, 2, 32'hFFFF_FFFF);
    issue(pli_pkg::OP_INSERT, 1, 32'h0000_0000);
    issue(pli_pkg::OP_INSERT, 6, 32'h1111_1111);
    issue(pli_pkg::OP_INSERT, 5, 32'h5A5A_A5A5);
    issue(pli_pkg::OP_DELETE, 6, 32'h0000_0000);
    issue(pli_pkg::OP_DELETE, 0, 32'h0000_0000);
    issue(pli_pkg::OP_DELETE, 3, 32'hDEAD_BEEF);
    issue(pli_pkg::OP_DELETE, 4, 32'h0000_0000);
    issue(pli_pkg::OP_DELETE, 1, 32'h0000_0000);
    issue(pli_pkg::OP_DELETE, 64, 32'h0000_0000);
    issue(pli_pkg::OP_INSERT, 64, 32'h0000_0000);
    drain();

    sent = 0;
    while (sent < 1300) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        issue_random();
        sent++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ;
        4, 5, 6, 7: idle($urandom_range(1, 12));
        8: idle($urandom_range(13, 150));
        default: drain();
      endcase
    end

    drain();
    repeat (200) @(posedge clk);
    if (failures == 0) begin
      $display("positional_list_insert_delete verification clean");
    end else begin
      $display("positional_list_insert_delete verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("positional_list_insert_delete verification failed");
    $finish;
  end

endmodule
